// ===== rtl/gbl_pkg.sv =====
// Shared constants, types and helpers for the bit-field layout packer.
package gbl_pkg;

   localparam int MAX_VARS  = 64;
   localparam int WORD_BITS = 32;
   localparam int IDX_W     = 6;
   localparam int CNT_W     = 7;
   localparam int WID_W     = 6;
   localparam int SHF_W     = 5;
   localparam int ATTR_W    = WID_W + 2;
   localparam int PLACE_W   = IDX_W + SHF_W;

   localparam logic [1:0] CLS_PUB  = 2'b00;
   localparam logic [1:0] CLS_PRIV = 2'b01;

   typedef struct packed {
      logic load;
      logic start;
      logic scan_start;
      logic scan_run;
      logic place;
      logic own_start;
      logic own_run;
      logic emit_start;
      logic emit_ld;
   } cmd_type;

   typedef struct packed {
      logic rem_zero;
      logic last_place;
      logic scan_done;
      logic own_done;
      logic out_free;
      logic emit_last;
   } sts_type;

   // bit length of max(count-1,1), capped at the word width
   function automatic logic [WID_W-1:0] bits_needed(input logic [32:0] count);
      logic [32:0] v;
      logic [WID_W:0] n;
      v = (count > 33'd1) ? count - 33'd1 : 33'd1;
      n = '0;
      for (int i = 0; i < 33; i++) begin
         if (v[i]) begin
            n = (WID_W+1)'(i + 1);
         end
      end
      if (n > (WID_W+1)'(WORD_BITS)) begin
         n = (WID_W+1)'(WORD_BITS);
      end
      return n[WID_W-1:0];
   endfunction

   function automatic logic [WORD_BITS-1:0] field_mask(input logic [WID_W-1:0] len,
                                                        input logic [SHF_W-1:0] shift);
      logic [WORD_BITS-1:0] ones;
      ones = (len >= WID_W'(WORD_BITS)) ? '1 : ((WORD_BITS'(1) << len) - WORD_BITS'(1));
      return ones << shift;
   endfunction

endpackage

// ===== rtl/gbl_ctrl.sv =====
// Sequencing state machine for the layout packer.
module gbl_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tlast,
   output logic             req_tready,
   input  gbl_pkg::sts_type sts,
   output gbl_pkg::cmd_type cmd
);
   import gbl_pkg::*;

   typedef enum logic [6:0] {
      S_LOAD    = 7'b0000001,
      S_START   = 7'b0000010,
      S_SCAN    = 7'b0000100,
      S_PLACE   = 7'b0001000,
      S_OWN     = 7'b0010000,
      S_EMIT_RD = 7'b0100000,
      S_EMIT_LD = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_LOAD: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
            if (req_tvalid && req_tlast) begin
               state_in = S_START;
            end
         end
         S_START: begin
            cmd.start = 1'b1;
            if (sts.rem_zero) begin
               cmd.own_start = 1'b1;
               state_in      = S_OWN;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_run = 1'b1;
            if (sts.scan_done) begin
               state_in = S_PLACE;
            end
         end
         S_PLACE: begin
            cmd.place = 1'b1;
            if (sts.last_place) begin
               cmd.own_start = 1'b1;
               state_in      = S_OWN;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = S_SCAN;
            end
         end
         S_OWN: begin
            cmd.own_run = 1'b1;
            if (sts.own_done) begin
               cmd.emit_start = 1'b1;
               state_in       = S_EMIT_RD;
            end
         end
         S_EMIT_RD: begin
            state_in = S_EMIT_LD;
         end
         S_EMIT_LD: begin
            if (sts.out_free) begin
               cmd.emit_ld = 1'b1;
               state_in    = sts.emit_last ? S_LOAD : S_EMIT_RD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

endmodule

// ===== rtl/gbl_dp.sv =====
// Datapath: descriptor and placement memories, scan, totals and result register.
module gbl_dp (
   input  logic             clock,
   input  logic             reset,
   input  gbl_pkg::cmd_type cmd,
   output gbl_pkg::sts_type sts,
   input  logic [39:0]      req_tdata,
   input  logic [1:0]       req_tuser,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [119:0]     rsp_tdata,
   output logic             rsp_tlast
);
   import gbl_pkg::*;

   logic [ATTR_W-1:0]  attr_mem  [MAX_VARS];
   logic [PLACE_W-1:0] place_mem [MAX_VARS];
   logic [ATTR_W-1:0]  attr_q_ff;
   logic [PLACE_W-1:0] place_q_ff;

   logic [CNT_W-1:0]    n_ff, left_pub_ff, left_priv_ff, word_cnt_ff, addr_ff;
   logic [WID_W:0]      filled_ff;
   logic [MAX_VARS-1:0] placed_ff;
   logic                chk_vld_ff;
   logic [IDX_W-1:0]    chk_idx_ff;
   logic                best_found_ff;
   logic [IDX_W-1:0]    best_idx_ff;
   logic [WID_W-1:0]    best_w_ff;
   logic                pub_seen_ff, priv_seen_ff;
   logic [IDX_W-1:0]    pub_last_ff, priv_first_ff, priv_last_ff;
   logic [WORD_BITS-1:0] pub_mask_ff, priv_mask_ff;

   logic             out_vld_ff, out_last_ff;
   logic [119:0]     out_data_ff;

   logic [1:0]       in_cls;
   logic [WID_W-1:0] q_w;
   logic [1:0]       q_cls;
   logic [1:0]       tgt_cls;
   logic             addr_more;
   logic             cand;
   logic [WID_W:0]   fill_new;
   logic [SHF_W-1:0] pl_shift;
   logic [IDX_W-1:0] pl_word;
   logic [WORD_BITS-1:0] pl_mask;
   logic             pl_pub;
   logic             place_we;
   logic [IDX_W-1:0] place_wa;
   logic [PLACE_W-1:0] place_wd;
   logic [CNT_W-1:0] priv_words;
   logic             emit_last;

   assign in_cls    = {req_tuser[1], req_tuser[0]};
   assign q_w       = attr_q_ff[WID_W-1:0];
   assign q_cls     = attr_q_ff[ATTR_W-1:WID_W];
   assign tgt_cls   = (left_pub_ff != '0) ? CLS_PUB : CLS_PRIV;
   assign addr_more = addr_ff < n_ff;

   // widest unplaced field of the active class that fits, lowest index on ties
   assign cand = chk_vld_ff && (q_cls == tgt_cls) && !placed_ff[chk_idx_ff]
              && ({1'b0, q_w} <= (WID_W+1)'(WORD_BITS) - filled_ff)
              && (!best_found_ff || q_w > best_w_ff);

   assign fill_new = filled_ff + {1'b0, best_w_ff};
   assign pl_shift = SHF_W'((WID_W+1)'(WORD_BITS) - fill_new);
   assign pl_word  = IDX_W'(word_cnt_ff - CNT_W'(1));
   assign pl_mask  = field_mask(best_w_ff, pl_shift);
   assign pl_pub   = (left_pub_ff != '0);

   always_comb begin
      place_we = 1'b0;
      place_wa = best_idx_ff;
      place_wd = {pl_word, pl_shift};
      if (cmd.place && best_found_ff) begin
         place_we = 1'b1;
      end else if (cmd.own_run && chk_vld_ff && q_cls[1]) begin
         place_we = 1'b1;
         place_wa = chk_idx_ff;
         place_wd = {word_cnt_ff[IDX_W-1:0], SHF_W'(0)};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && n_ff < CNT_W'(MAX_VARS)) begin
         attr_mem[n_ff[IDX_W-1:0]] <= {in_cls, bits_needed(req_tdata[32:0])};
      end
      if (place_we) begin
         place_mem[place_wa] <= place_wd;
      end
      attr_q_ff  <= attr_mem[addr_ff[IDX_W-1:0]];
      place_q_ff <= place_mem[addr_ff[IDX_W-1:0]];
   end

   assign priv_words = priv_seen_ff ? CNT_W'(priv_last_ff - priv_first_ff) + CNT_W'(1) : '0;
   assign emit_last  = (addr_ff + CNT_W'(1)) == n_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff         <= '0;
         left_pub_ff  <= '0;
         left_priv_ff <= '0;
         chk_vld_ff   <= 1'b0;
         out_vld_ff   <= 1'b0;
      end else begin
         if (cmd.load && n_ff < CNT_W'(MAX_VARS)) begin
            n_ff <= n_ff + CNT_W'(1);
            if (in_cls == CLS_PUB) begin
               left_pub_ff <= left_pub_ff + CNT_W'(1);
            end
            if (in_cls == CLS_PRIV) begin
               left_priv_ff <= left_priv_ff + CNT_W'(1);
            end
         end
         if (cmd.place && best_found_ff) begin
            if (pl_pub) begin
               left_pub_ff <= left_pub_ff - CNT_W'(1);
            end else begin
               left_priv_ff <= left_priv_ff - CNT_W'(1);
            end
         end
         if (cmd.scan_start || cmd.own_start || cmd.emit_start) begin
            chk_vld_ff <= 1'b0;
         end else if (cmd.scan_run || cmd.own_run) begin
            chk_vld_ff <= addr_more;
         end
         if (cmd.emit_ld) begin
            out_vld_ff <= 1'b1;
            if (emit_last) begin
               n_ff <= '0;
            end
         end else if (rsp_tready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_start || cmd.own_start || cmd.emit_start) begin
         addr_ff <= '0;
      end else if ((cmd.scan_run || cmd.own_run) && addr_more) begin
         addr_ff    <= addr_ff + CNT_W'(1);
         chk_idx_ff <= addr_ff[IDX_W-1:0];
      end else if (cmd.emit_ld) begin
         addr_ff <= addr_ff + CNT_W'(1);
      end

      if (cmd.scan_start) begin
         best_found_ff <= 1'b0;
      end else if (cmd.scan_run && cand) begin
         best_found_ff <= 1'b1;
         best_idx_ff   <= chk_idx_ff;
         best_w_ff     <= q_w;
      end

      if (cmd.start) begin
         word_cnt_ff  <= (left_pub_ff != '0 || left_priv_ff != '0) ? CNT_W'(1) : '0;
         filled_ff    <= '0;
         placed_ff    <= '0;
         pub_seen_ff  <= 1'b0;
         priv_seen_ff <= 1'b0;
         pub_last_ff  <= '0;
         pub_mask_ff  <= '0;
         priv_first_ff <= '0;
         priv_last_ff <= '0;
         priv_mask_ff <= '0;
      end else if (cmd.place) begin
         if (best_found_ff) begin
            placed_ff[best_idx_ff] <= 1'b1;
            filled_ff <= fill_new;
            if (pl_pub) begin
               pub_seen_ff <= 1'b1;
               pub_last_ff <= pl_word;
               if (!pub_seen_ff || pl_word != pub_last_ff) begin
                  pub_mask_ff <= pl_mask;
               end else begin
                  pub_mask_ff <= pub_mask_ff | pl_mask;
               end
            end else begin
               priv_seen_ff <= 1'b1;
               priv_last_ff <= pl_word;
               if (!priv_seen_ff) begin
                  priv_first_ff <= pl_word;
                  priv_mask_ff  <= pl_mask;
               end else if (pl_word == priv_first_ff) begin
                  priv_mask_ff <= priv_mask_ff | pl_mask;
               end
            end
         end else begin
            // nothing fits: open a fresh word
            word_cnt_ff <= word_cnt_ff + CNT_W'(1);
            filled_ff   <= '0;
         end
      end else if (cmd.own_run && chk_vld_ff && q_cls[1]) begin
         word_cnt_ff <= word_cnt_ff + CNT_W'(1);
      end

      if (cmd.emit_ld) begin
         out_last_ff <= emit_last;
         out_data_ff <= {7'd0, priv_words, priv_mask_ff, priv_first_ff, pub_mask_ff,
                         pub_last_ff, word_cnt_ff,
                         (q_cls[1] ? WID_W'(WORD_BITS) : q_w),
                         place_q_ff[SHF_W-1:0], place_q_ff[PLACE_W-1:SHF_W],
                         addr_ff[IDX_W-1:0]};
      end
   end

   assign sts.rem_zero   = (left_pub_ff == '0) && (left_priv_ff == '0);
   assign sts.last_place = best_found_ff && (left_pub_ff + left_priv_ff == CNT_W'(1));
   assign sts.scan_done  = !addr_more && !chk_vld_ff;
   assign sts.own_done   = !addr_more && !chk_vld_ff;
   assign sts.out_free   = !out_vld_ff || rsp_tready;
   assign sts.emit_last  = emit_last;

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== rtl/greedy_bitfield_layout_packer.sv =====
// Top level of the greedy bit-field layout packer.
// Loading: one descriptor transfer per cycle in the load state; the next batch is taken
// only after the last result is loaded. After the last of n descriptors, each placement
// step rescans the n-entry memory: one step per public or private variable plus one per
// word closed early. An own-word pass follows; results then leave one at a time.
// Reset (synchronous, active high) empties the batch and the result register.
module greedy_bitfield_layout_packer (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [39:0]  req_tdata,  // value_count[32:0], zero pad
   input  logic [1:0]   req_tuser,  // priv_flag[0], own_word[1]
   input  logic         req_tlast,  // last_var
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [119:0] rsp_tdata,  // var_index, word_pos, bit_shift, bit_len,
                                    // total_words, pub_top_word, pub_last_mask,
                                    // priv_first_word, priv_first_mask, priv_words
   output logic         rsp_tlast   // last_result
);
   import gbl_pkg::*;

   cmd_type cmd;
   sts_type sts;

   gbl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   gbl_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
